// ===== src/mcm_pkg.sv =====
// Shared types and constants for the matrix chain minimum cost block.
`default_nettype none
package mcm_pkg;

	localparam int DIM_FIELD_BITS = 16;
	localparam int COST_BITS = 52;
	localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

	typedef struct packed {
		logic [DIM_FIELD_BITS-1:0] dimension;
		logic                      last;
	} dim_word_t;

	typedef struct packed {
		logic [COST_BITS-1:0] min_cost;
		logic                 status;
	} res_word_t;

	// Controls from the sequencer to the shared step unit.
	typedef struct packed {
		logic load_di;    // latch d[i-1] from the dimension read port
		logic load_dij;   // multiply d[i-1] by d[j]
		logic mult_k;     // multiply d[i-1]*d[j] by d[k], add the two sub-costs
		logic compare;    // add the product, keep the smaller of candidate and best
		logic init_best;  // start an interval at the saturation value
		logic zero_best;  // short chain: cost is zero
		logic left_diag;  // left sub-chain is a single matrix
		logic right_diag; // right sub-chain is a single matrix
	} step_ctrl_t;

endpackage
`default_nettype wire

// ===== src/mcm_dim_mem.sv =====
// Dimension store: one write port, one registered read port.
`default_nettype none
module mcm_dim_mem #(
	parameter int DEPTH = 17,
	parameter int DIM_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DIM_BITS-1:0]      wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DIM_BITS-1:0]      rdata
);

	logic [DIM_BITS-1:0] mem_q [DEPTH];
	logic [DIM_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/mcm_cost_mem.sv =====
// Interval cost table: one write port, two registered read ports, row/column address.
`default_nettype none
module mcm_cost_mem #(
	parameter int IDX_BITS = 5
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [2*IDX_BITS-1:0]         waddr,
	input  wire logic [mcm_pkg::COST_BITS-1:0] wdata,
	input  wire logic [2*IDX_BITS-1:0]         raddr_a,
	input  wire logic [2*IDX_BITS-1:0]         raddr_b,
	output logic      [mcm_pkg::COST_BITS-1:0] rdata_a,
	output logic      [mcm_pkg::COST_BITS-1:0] rdata_b
);

	localparam int DEPTH = 2 ** (2 * IDX_BITS);

	logic [mcm_pkg::COST_BITS-1:0] mem_q [DEPTH];
	logic [mcm_pkg::COST_BITS-1:0] rdata_a_q;
	logic [mcm_pkg::COST_BITS-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule
`default_nettype wire

// ===== src/mcm_step_unit.sv =====
// Shared multiply, add and compare unit that evaluates one split point at a time.
`default_nettype none
module mcm_step_unit #(
	parameter int DIM_BITS = 16
) (
	input  wire logic                          clk,
	input  wire mcm_pkg::step_ctrl_t           ctrl,
	input  wire logic [DIM_BITS-1:0]           dim_rdata,
	input  wire logic [mcm_pkg::COST_BITS-1:0] cost_a,
	input  wire logic [mcm_pkg::COST_BITS-1:0] cost_b,
	output logic      [mcm_pkg::COST_BITS-1:0] best
);

	localparam int PW = 3 * DIM_BITS;
	localparam int CB = mcm_pkg::COST_BITS;

	logic [DIM_BITS-1:0]   di_q;
	logic [2*DIM_BITS-1:0] dij_q;
	logic [PW-1:0]         prod_q;
	logic [CB:0]           csum_q;
	logic [CB-1:0]         best_q;

	logic [2*DIM_BITS-1:0] mul_a;
	logic [PW-1:0]         mul_p;
	logic [CB-1:0]         left_cost;
	logic [CB-1:0]         right_cost;
	logic [CB:0]           csum;
	logic [CB+1:0]         cand;
	logic                  take;

	// One multiplier serves both d[i-1]*d[j] and (d[i-1]*d[j])*d[k].
	assign mul_a = ctrl.load_dij ? {{DIM_BITS{1'b0}}, di_q} : dij_q;
	assign mul_p = mul_a * dim_rdata;

	assign left_cost  = ctrl.left_diag ? '0 : cost_a;
	assign right_cost = ctrl.right_diag ? '0 : cost_b;
	assign csum       = {1'b0, left_cost} + {1'b0, right_cost};

	assign cand = {1'b0, csum_q} + (CB + 2)'(prod_q);
	assign take = cand < {2'b00, best_q};

	always_ff @(posedge clk) begin
		if (ctrl.load_di) begin
			di_q <= dim_rdata;
		end
		if (ctrl.load_dij) begin
			dij_q <= mul_p[2*DIM_BITS-1:0];
		end
		if (ctrl.mult_k) begin
			prod_q <= mul_p;
			csum_q <= csum;
		end
		if (ctrl.zero_best) begin
			best_q <= '0;
		end else if (ctrl.init_best) begin
			best_q <= mcm_pkg::COST_MAX;
		end else if (ctrl.compare && take) begin
			best_q <= cand[CB-1:0];
		end
	end

	assign best = best_q;

endmodule
`default_nettype wire

// ===== src/matrix_chain_min_cost.sv =====
// Top level: dimension intake, interval sequencer and result register.
//
//   channel | direction | payload                 | handshake
//   --------+-----------+-------------------------+----------------------
//   dim     | in        | dimension[16], last     | dim_valid / dim_stall
//   res     | out       | min_cost[52], status    | res_valid / res_stall
//
// Dimensions load one word per cycle while dim_stall is low. After the word
// marked last, the sequencer fills the cost table by chain length (a chain
// of fewer than two matrices skips this): each interval takes three set-up
// states, three states per split point through the shared multiplier and
// compare unit, and one table-write state; after the last interval the
// result is emitted. dim_stall is high for all of that. A waiting result
// does not block intake of the next chain; the emit state holds only while
// the result register is full and stalled. Reset clears the sequencer,
// counts and result valid; the stores hold garbage until written.
`default_nettype none
module matrix_chain_min_cost #(
	parameter int MAX_MATRICES = 16,
	parameter int DIM_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               dim_valid,
	output logic                    dim_stall,
	input  wire mcm_pkg::dim_word_t dim_word,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output mcm_pkg::res_word_t      res_word
);

	localparam int CAP = MAX_MATRICES + 1;
	localparam int IB  = $clog2(CAP);
	localparam int CNB = $clog2(CAP + 1);
	localparam logic [CNB-1:0] CAP_CNT = CNB'(CAP);

	typedef enum logic [8:0] {
		S_LOAD = 9'b000000001,
		S_IVL0 = 9'b000000010,
		S_IVL1 = 9'b000000100,
		S_IVL2 = 9'b000001000,
		S_K0   = 9'b000010000,
		S_K1   = 9'b000100000,
		S_K2   = 9'b001000000,
		S_WR   = 9'b010000000,
		S_EMIT = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [CNB-1:0]     cnt_q;
	logic               ovf_q;
	logic [IB-1:0]      mats_q;
	logic [IB-1:0]      len_q;
	logic [IB-1:0]      i_q;
	logic [IB-1:0]      j_q;
	logic [IB-1:0]      k_q;
	logic               res_valid_q;
	mcm_pkg::res_word_t res_word_q;

	logic                          dim_acc;
	logic                          room;
	logic [CNB-1:0]                cnt_next;
	logic [IB-1:0]                 mats_next;
	logic [IB-1:0]                 k_plus1;
	logic [IB-1:0]                 dim_raddr;
	logic [DIM_BITS-1:0]           dim_rdata;
	logic [mcm_pkg::COST_BITS-1:0] cost_a;
	logic [mcm_pkg::COST_BITS-1:0] cost_b;
	logic [mcm_pkg::COST_BITS-1:0] best;
	logic                          emit_go;
	mcm_pkg::step_ctrl_t           ctrl;

	assign dim_stall = (state_q != S_LOAD);
	assign dim_acc   = dim_valid && !dim_stall;
	assign room      = (cnt_q < CAP_CNT);
	assign cnt_next  = room ? cnt_q + CNB'(1) : cnt_q;
	// The first word of a chain always fits, so cnt_next is at least one.
	assign mats_next = IB'(cnt_next - CNB'(1));
	assign k_plus1   = k_q + IB'(1);
	assign emit_go   = (state_q == S_EMIT) && (!res_valid_q || !res_stall);

	// Dimension read address: d[i-1], then d[j], then d[k] per split point.
	always_comb begin
		unique case (state_q)
			S_IVL0:  dim_raddr = i_q - IB'(1);
			S_IVL1:  dim_raddr = j_q;
			default: dim_raddr = k_q;
		endcase
	end

	always_comb begin
		ctrl            = '0;
		ctrl.load_di    = (state_q == S_IVL1);
		ctrl.load_dij   = (state_q == S_IVL2);
		ctrl.init_best  = (state_q == S_IVL2);
		ctrl.mult_k     = (state_q == S_K1);
		ctrl.compare    = (state_q == S_K2);
		ctrl.zero_best  = dim_acc && dim_word.last && (mats_next < IB'(2));
		ctrl.left_diag  = (k_q == i_q);
		ctrl.right_diag = (k_plus1 == j_q);
	end

	mcm_dim_mem #(
		.DEPTH    (CAP),
		.DIM_BITS (DIM_BITS)
	) u_dim_mem (
		.clk   (clk),
		.we    (dim_acc && room),
		.waddr (cnt_q[IB-1:0]),
		.wdata (dim_word.dimension[DIM_BITS-1:0]),
		.raddr (dim_raddr),
		.rdata (dim_rdata)
	);

	mcm_cost_mem #(
		.IDX_BITS (IB)
	) u_cost_mem (
		.clk     (clk),
		.we      (state_q == S_WR),
		.waddr   ({i_q, j_q}),
		.wdata   (best),
		.raddr_a ({i_q, k_q}),
		.raddr_b ({k_plus1, j_q}),
		.rdata_a (cost_a),
		.rdata_b (cost_b)
	);

	mcm_step_unit #(
		.DIM_BITS (DIM_BITS)
	) u_step (
		.clk       (clk),
		.ctrl      (ctrl),
		.dim_rdata (dim_rdata),
		.cost_a    (cost_a),
		.cost_b    (cost_b),
		.best      (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			mats_q  <= '0;
			len_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (dim_acc) begin
						// Store while there is room, otherwise drop and flag.
						cnt_q <= cnt_next;
						ovf_q <= ovf_q | !room;
						if (dim_word.last) begin
							mats_q <= mats_next;
							len_q  <= IB'(2);
							i_q    <= IB'(1);
							state_q <= (mats_next < IB'(2)) ? S_EMIT : S_IVL0;
						end
					end
				end
				S_IVL0: begin
					j_q     <= i_q + len_q - IB'(1);
					state_q <= S_IVL1;
				end
				S_IVL1: begin
					state_q <= S_IVL2;
				end
				S_IVL2: begin
					k_q     <= i_q;
					state_q <= S_K0;
				end
				S_K0: begin
					state_q <= S_K1;
				end
				S_K1: begin
					state_q <= S_K2;
				end
				S_K2: begin
					if (k_plus1 == j_q) begin
						state_q <= S_WR;
					end else begin
						k_q     <= k_plus1;
						state_q <= S_K0;
					end
				end
				S_WR: begin
					// Advance to the next interval, or the next length at the row's end.
					if (j_q == mats_q) begin
						if (len_q == mats_q) begin
							state_q <= S_EMIT;
						end else begin
							len_q   <= len_q + IB'(1);
							i_q     <= IB'(1);
							state_q <= S_IVL0;
						end
					end else begin
						i_q     <= i_q + IB'(1);
						state_q <= S_IVL0;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Result register: hold while stalled, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_word_q.min_cost <= best;
			res_word_q.status   <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule
`default_nettype wire

// ===== src/mcm_checker.sv =====
// Port-level checks for the matrix chain minimum cost block, with its bind.
`default_nettype none
module mcm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               dim_valid,
	input wire logic               dim_stall,
	input wire mcm_pkg::dim_word_t dim_word,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire mcm_pkg::res_word_t res_word
);

	// A stalled result word holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	// Closing a chain starts the table fill (or, for a short chain, the emit), so intake stops.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		dim_valid && !dim_stall && dim_word.last |=> dim_stall)
		else $error("intake open right after the last dimension");

	// A new result comes only out of a busy stretch.
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(dim_stall))
		else $error("result appeared without a computation");

	// Emitting a result reopens intake.
	a_open_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !dim_stall)
		else $error("intake still closed after a result");

endmodule

bind matrix_chain_min_cost mcm_checker u_mcm_checker (.*);
`default_nettype wire
